FILE: rtl/krt_pkg.sv
package krt_pkg;

  // operation codes carried in s_tuser
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_FIND   = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  // status codes carried in m_tuser
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

  localparam logic [8:0] CAP_RESET = 9'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_FIND,
    ST_REMOVE,
    ST_REM_WRITE,
    ST_READ,
    ST_READ_DATA,
    ST_DONE
  } krt_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [15:0] handle;
    logic [7:0]  index;
  } krt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_index;
    logic [31:0] found_key;
    logic [15:0] found_handle;
    logic [8:0]  entry_count;
    logic [8:0]  capacity;
  } krt_result_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] handle;
  } krt_entry_t;

endpackage

FILE: rtl/krt_ram.sv
module krt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/krt_ctrl.sv
module krt_ctrl import krt_pkg::*; #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        req_valid,
  output logic        req_ready,
  input  krt_req_t    req_in,
  output logic        res_valid,
  input  logic        res_ready,
  output krt_result_t res_out
);

  localparam int AW     = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
  localparam int CFG_W  = (CNT_W > 9) ? CNT_W : 9;
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W:0]   MAX_WIDE = (CNT_W + 1)'(MAX_ENTRIES);
  localparam logic [CFG_W-1:0] MAX_CFG  = CFG_W'(MAX_ENTRIES);

  krt_state_t        state, state_next;
  krt_req_t          req;
  krt_result_t       res;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  scan_idx;
  logic              cmp_valid;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  krt_entry_t        ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  krt_entry_t        ram_rdata;

  logic              idx_ok;
  logic              scan_more;
  logic              key_hit;
  logic [CNT_W:0]    cap_dbl;
  logic [CNT_W-1:0]  cap_grown;
  logic [CNT_W-1:0]  count_dec;
  logic [CFG_W-1:0]  cfg_ext;
  logic [CNT_W-1:0]  cfg_cap;

  krt_ram #(
    .WIDTH($bits(krt_entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign idx_ok    = CMP_W'(req.index) < CMP_W'(count);
  assign scan_more = scan_idx < count;
  assign key_hit   = cmp_valid && (ram_rdata.key == req.key);
  assign cap_dbl   = {cap, 1'b0};
  assign cap_grown = (cap_dbl > MAX_WIDE) ? MAX_CNT : cap_dbl[CNT_W-1:0];
  assign count_dec = count - CNT_W'(1);

  // clamp the written capacity into 1..MAX_ENTRIES
  always_comb begin
    cfg_ext = CFG_W'(cfg_wdata);
    if (cfg_wdata == 9'd0) begin
      cfg_cap = CNT_W'(1);
    end else if (cfg_ext > MAX_CFG) begin
      cfg_cap = MAX_CNT;
    end else begin
      cfg_cap = cfg_ext[CNT_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req_in.req_type)
            REQ_INSERT: state_next = ST_INSERT;
            REQ_FIND:   state_next = ST_FIND;
            REQ_REMOVE: state_next = ST_REMOVE;
            REQ_READ:   state_next = ST_READ;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_INSERT:    state_next = ST_DONE;
      ST_FIND: begin
        if (key_hit || !scan_more) begin
          state_next = ST_DONE;
        end
      end
      ST_REMOVE:    state_next = idx_ok ? ST_REM_WRITE : ST_DONE;
      ST_REM_WRITE: state_next = ST_DONE;
      ST_READ:      state_next = idx_ok ? ST_READ_DATA : ST_DONE;
      ST_READ_DATA: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = '{key: req.key, handle: req.handle};
    ram_re    = 1'b0;
    ram_raddr = scan_idx[AW-1:0];
    unique case (state)
      ST_IDLE: req_ready = 1'b1;
      ST_INSERT: begin
        ram_we = (count != MAX_CNT);
      end
      ST_FIND: begin
        ram_re = scan_more;
      end
      ST_REMOVE: begin
        // fetch the last entry to move into the freed slot
        ram_re    = idx_ok;
        ram_raddr = count_dec[AW-1:0];
      end
      ST_REM_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(req.index);
        ram_wdata = ram_rdata;
      end
      ST_READ: begin
        ram_re    = idx_ok;
        ram_raddr = AW'(req.index);
      end
      ST_READ_DATA: ;
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res_out             = res;
    res_out.entry_count = 9'(count);
    res_out.capacity    = 9'(cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cap       <= CNT_W'(CAP_RESET);
      cmp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cap <= cfg_cap;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            req       <= req_in;
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            res       <= '0;
          end
        end
        ST_INSERT: begin
          if (count == MAX_CNT) begin
            res.status <= STAT_FULL;
          end else begin
            count <= count + CNT_W'(1);
            if (count >= cap) begin
              cap <= cap_grown;
            end
          end
        end
        ST_FIND: begin
          // read of entry scan_idx overlaps the compare of the one before
          scan_idx  <= scan_idx + CNT_W'(1);
          cmp_valid <= scan_more;
          if (key_hit) begin
            res.found_index  <= 8'(scan_idx - CNT_W'(1));
            res.found_key    <= ram_rdata.key;
            res.found_handle <= ram_rdata.handle;
          end else if (!scan_more) begin
            res.status <= STAT_NOT_FOUND;
          end
        end
        ST_REMOVE: begin
          if (!idx_ok) begin
            res.status <= STAT_BAD_INDEX;
          end
        end
        ST_REM_WRITE: begin
          count <= count_dec;
          if ((count_dec < (cap >> 2)) && (cap >= CNT_W'(4))) begin
            cap <= cap >> 1;
          end
        end
        ST_READ: begin
          if (!idx_ok) begin
            res.status <= STAT_BAD_INDEX;
          end
        end
        ST_READ_DATA: begin
          res.found_key    <= ram_rdata.key;
          res.found_handle <= ram_rdata.handle;
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/keyed_record_table_top.sv
// insert writes the entry directly; read and remove check the index and, if it is valid,
// read or move an entry; find compares one stored entry per cycle (one ram read port)
// and stops at the first hit. one item is worked on at a time; the next item is taken
// once the result is in the output register
// reset clears the fill count and loads capacity 4; table contents stay undefined
module keyed_record_table_top import krt_pkg::*; #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,   // initial_capacity
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,     // key[31:0], handle[47:32], index[55:48]
  input  logic [1:0]  s_tuser,     // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,     // found_index[7:0], found_key[39:8], found_handle[55:40],
                                   // entry_count[64:56], capacity[73:65], zero fill above
  output logic [1:0]  m_tuser      // status
);

  krt_req_t    req_in;
  krt_result_t res_out;
  krt_result_t out_reg;
  logic        res_valid;
  logic        res_ready;

  assign req_in.req_type = s_tuser;
  assign req_in.key      = s_tdata[31:0];
  assign req_in.handle   = s_tdata[47:32];
  assign req_in.index    = s_tdata[55:48];

  assign res_ready = !m_tvalid || m_tready;

  krt_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req_valid(s_tvalid),
    .req_ready(s_tready),
    .req_in   (req_in),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_out  (res_out)
  );

  // output register lets the sequencer take the next item while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_reg <= res_out;
    end
  end

  assign m_tuser = out_reg.status;
  assign m_tdata = {6'd0, out_reg.capacity, out_reg.entry_count, out_reg.found_handle,
                    out_reg.found_key, out_reg.found_index};

endmodule
